### sv/huffman_tree_bit_decoder_core_assert.svh
// assertion macros for the huffman tree bit decoder
`ifndef HUFFMAN_TREE_BIT_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_TREE_BIT_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define HTBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/htbd_pkg.sv
`timescale 1ns / 1ps
package htbd_pkg;

  localparam int MaxNodes = 512;
  localparam int MemAw    = $clog2(MaxNodes);
  localparam int IdxW     = 9;
  localparam int SymW     = 8;

  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdDecode = 1'b1;

  typedef struct packed {
    logic            right_present;
    logic            left_present;
    logic [IdxW-1:0] right_index;
    logic [IdxW-1:0] left_index;
    logic [SymW-1:0] symbol;
  } node_t;

  localparam int NodeW = $bits(node_t);

  function automatic logic in_table(input logic [IdxW-1:0] idx);
    in_table = 32'(idx) < 32'(MaxNodes);
  endfunction

  function automatic logic [MemAw-1:0] to_addr(input logic [IdxW-1:0] idx);
    logic [31:0] wide;
    wide    = 32'(idx);
    to_addr = wide[MemAw-1:0];
  endfunction

endpackage

### sv/huffman_tree_bit_decoder_core.sv
// Huffman tree bit decoder. The code tree lives in a node table of MaxNodes
// single-port-read entries; a load word writes one node. A decode word reads
// the root entry and the current walk node, then steps through the code bits
// msb first; a bit that moves to a present child reads that child's entry
// from the table and checks it in a further state, since the entry comes back
// from the table registered. The walk ends in a flush state that releases the
// final result with last set. The next word is taken only once the byte is
// finished; results leave through an output register, so a stall there holds
// the walk only when two results are waiting.
`timescale 1ns / 1ps
`include "huffman_tree_bit_decoder_core_assert.svh"
module huffman_tree_bit_decoder_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [htbd_pkg::IdxW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [htbd_pkg::IdxW-1:0] node_index_i,
  input  logic [htbd_pkg::IdxW-1:0] left_index_i,
  input  logic [htbd_pkg::IdxW-1:0] right_index_i,
  input  logic                      left_present_i,
  input  logic                      right_present_i,
  input  logic [htbd_pkg::SymW-1:0] node_symbol_i,
  input  logic [htbd_pkg::SymW-1:0] code_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [htbd_pkg::SymW-1:0] symbol_o,
  output logic                      bad_path_o,
  output logic                      last_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_RD_ROOT = 6'b000010,
    ST_RD_CUR  = 6'b000100,
    ST_STEP    = 6'b001000,
    ST_CHILD   = 6'b010000,
    ST_FLUSH   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [htbd_pkg::IdxW-1:0] root_q, pos_q, pos_d, child_q, child_d;
  logic [htbd_pkg::SymW-1:0] sh_q, sh_d;
  logic [2:0]                cnt_q, cnt_d;
  logic                      lastbit_q, lastbit_d;
  htbd_pkg::node_t           root_ent_q, root_ent_d, cur_ent_q, cur_ent_d;
  logic                      rd_oob_q;

  logic                      pend_v_q, pend_v_d, pend_bad_q, pend_bad_d;
  logic [htbd_pkg::SymW-1:0] pend_sym_q, pend_sym_d;

  logic                      out_v_q, out_bad_q, out_last_q;
  logic [htbd_pkg::SymW-1:0] out_sym_q;
  logic                      out_load;
  logic                      out_last_d;

  logic                        mem_we, mem_re, rd_oob_d;
  logic [htbd_pkg::MemAw-1:0]  mem_waddr, mem_raddr;
  logic [htbd_pkg::NodeW-1:0]  mem_rdata;
  htbd_pkg::node_t             wr_ent, rd_ent;

  logic                      in_acc, slot_free, can_emit;
  logic                      bit_v, present, bad;
  logic [htbd_pkg::IdxW-1:0] child;
  logic                      leaf;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_v_q || out_ready_i;
  assign can_emit   = !pend_v_q || slot_free;

  assign wr_ent = '{right_present: right_present_i, left_present: left_present_i,
                    right_index: right_index_i, left_index: left_index_i,
                    symbol: node_symbol_i};
  assign mem_we    = in_acc && (cmd_i == htbd_pkg::CmdLoad) && htbd_pkg::in_table(node_index_i);
  assign mem_waddr = htbd_pkg::to_addr(node_index_i);

  assign rd_ent = rd_oob_q ? htbd_pkg::node_t'('0) : htbd_pkg::node_t'(mem_rdata);

  assign bit_v   = sh_q[htbd_pkg::SymW-1];
  assign present = bit_v ? cur_ent_q.right_present : cur_ent_q.left_present;
  assign child   = bit_v ? cur_ent_q.right_index : cur_ent_q.left_index;
  assign bad     = !present || !htbd_pkg::in_table(child);
  assign leaf    = !rd_ent.left_present && !rd_ent.right_present;

  htbd_ram #(
    .Depth(htbd_pkg::MaxNodes),
    .Width(htbd_pkg::NodeW)
  ) u_node_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(wr_ent),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    child_d    = child_q;
    sh_d       = sh_q;
    cnt_d      = cnt_q;
    lastbit_d  = lastbit_q;
    root_ent_d = root_ent_q;
    cur_ent_d  = cur_ent_q;
    pend_v_d   = pend_v_q;
    pend_bad_d = pend_bad_q;
    pend_sym_d = pend_sym_q;
    out_load   = 1'b0;
    out_last_d = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = htbd_pkg::to_addr(root_q);
    rd_oob_d   = !htbd_pkg::in_table(root_q);

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd_i == htbd_pkg::CmdDecode)) begin
          mem_re  = 1'b1;
          sh_d    = code_byte_i;
          cnt_d   = '0;
          state_d = ST_RD_ROOT;
        end
      end
      ST_RD_ROOT: begin
        root_ent_d = rd_ent;
        mem_re     = 1'b1;
        mem_raddr  = htbd_pkg::to_addr(pos_q);
        rd_oob_d   = !htbd_pkg::in_table(pos_q);
        state_d    = ST_RD_CUR;
      end
      ST_RD_CUR: begin
        cur_ent_d = rd_ent;
        state_d   = ST_STEP;
      end
      ST_STEP: begin
        if (bad) begin
          if (can_emit) begin
            out_load   = pend_v_q;
            pend_v_d   = 1'b1;
            pend_bad_d = 1'b1;
            pend_sym_d = '0;
            cur_ent_d  = root_ent_q;
            pos_d      = root_q;
            sh_d       = sh_q << 1;
            cnt_d      = cnt_q + 3'd1;
            state_d    = (cnt_q == 3'd7) ? ST_FLUSH : ST_STEP;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = htbd_pkg::to_addr(child);
          rd_oob_d  = 1'b0;
          child_d   = child;
          lastbit_d = (cnt_q == 3'd7);
          sh_d      = sh_q << 1;
          cnt_d     = cnt_q + 3'd1;
          state_d   = ST_CHILD;
        end
      end
      ST_CHILD: begin
        if (leaf) begin
          if (can_emit) begin
            out_load   = pend_v_q;
            pend_v_d   = 1'b1;
            pend_bad_d = 1'b0;
            pend_sym_d = rd_ent.symbol;
            cur_ent_d  = root_ent_q;
            pos_d      = root_q;
            state_d    = lastbit_q ? ST_FLUSH : ST_STEP;
          end
        end else begin
          cur_ent_d = rd_ent;
          pos_d     = child_q;
          state_d   = lastbit_q ? ST_FLUSH : ST_STEP;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      root_q   <= '0;
      pos_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
        pos_q  <= cfg_wdata_i;
      end else begin
        pos_q <= pos_d;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    child_q    <= child_d;
    sh_q       <= sh_d;
    cnt_q      <= cnt_d;
    lastbit_q  <= lastbit_d;
    root_ent_q <= root_ent_d;
    cur_ent_q  <= cur_ent_d;
    pend_bad_q <= pend_bad_d;
    pend_sym_q <= pend_sym_d;
    if (mem_re) begin
      rd_oob_q <= rd_oob_d;
    end
    if (out_load) begin
      out_sym_q  <= pend_sym_q;
      out_bad_q  <= pend_bad_q;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign symbol_o    = out_sym_q;
  assign bad_path_o  = out_bad_q;
  assign last_o      = out_last_q;

  `HTBD_ASSERT_NOW(a_idle_no_pending, in_ready_o, !pend_v_q,
    "result left pending while taking a new word")
  `HTBD_ASSERT_NOW(a_bad_sym_zero, out_valid_o && bad_path_o, symbol_o == '0,
    "error result with nonzero symbol")
  `HTBD_ASSERT_NEXT(a_child_after_step, state_q == ST_STEP && !bad, state_q == ST_CHILD,
    "child read not followed by child check")

endmodule

### sv/htbd_ram.sv
`timescale 1ns / 1ps
module htbd_ram #(
  parameter int Depth = 512,
  parameter int Width = 28
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int IdxW     = htbd_pkg::IdxW;
  localparam int SymW     = htbd_pkg::SymW;
  localparam int MaxNodes = htbd_pkg::MaxNodes;

  typedef htbd_pkg::node_t node_t;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 40;
  localparam int PhaseWords   = 66;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            bad_path;
    logic            last;
  } sym_word_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [IdxW-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_ready_o;
  logic            cmd_i;
  logic [IdxW-1:0] node_index_i;
  logic [IdxW-1:0] left_index_i;
  logic [IdxW-1:0] right_index_i;
  logic            left_present_i;
  logic            right_present_i;
  logic [SymW-1:0] node_symbol_i;
  logic [SymW-1:0] code_byte_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [SymW-1:0] symbol_o;
  logic            bad_path_o;
  logic            last_o;

  huffman_tree_bit_decoder_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .node_index_i   (node_index_i),
    .left_index_i   (left_index_i),
    .right_index_i  (right_index_i),
    .left_present_i (left_present_i),
    .right_present_i(right_present_i),
    .node_symbol_i  (node_symbol_i),
    .code_byte_i    (code_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_o       (symbol_o),
    .bad_path_o     (bad_path_o),
    .last_o         (last_o)
  );

  node_t           node_mem    [MaxNodes];
  bit              node_loaded [MaxNodes];
  int              loaded_q[$];
  logic [IdxW-1:0] root_idx;
  logic [IdxW-1:0] walk_idx;
  sym_word_t       sym_expect_q[$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          err_count      = 0;
  int          words_sent;
  int          loads_sent;
  int          bytes_sent;
  int          words_checked  = 0;
  int          bad_paths_seen = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [IdxW-1:0] pick_loaded_node();
    return IdxW'(loaded_q[$urandom_range(loaded_q.size() - 1)]);
  endfunction

  function automatic void apply_node_load(input logic [IdxW-1:0] nidx, input node_t entry);
    node_mem[nidx] = entry;
    if (!node_loaded[nidx]) begin
      node_loaded[nidx] = 1'b1;
      loaded_q.push_back(int'(nidx));
    end
  endfunction

  // walk eight bits msb first, one result per leaf or dead end
  function automatic void predict_code_byte(input logic [SymW-1:0] code);
    sym_word_t       byte_words[$];
    sym_word_t       w;
    node_t           cur;
    node_t           nxt;
    logic            present;
    logic [IdxW-1:0] child;
    for (int i = SymW - 1; i >= 0; i--) begin
      cur     = node_mem[walk_idx];
      present = code[i] ? cur.right_present : cur.left_present;
      child   = code[i] ? cur.right_index : cur.left_index;
      if (!present) begin
        w = '{symbol: '0, bad_path: 1'b1, last: 1'b0};
        byte_words.push_back(w);
        walk_idx = root_idx;
      end else begin
        nxt = node_mem[child];
        if (!nxt.left_present && !nxt.right_present) begin
          w = '{symbol: nxt.symbol, bad_path: 1'b0, last: 1'b0};
          byte_words.push_back(w);
          walk_idx = root_idx;
        end else begin
          walk_idx = child;
        end
      end
    end
    if (byte_words.size() > 0) byte_words[byte_words.size() - 1].last = 1'b1;
    foreach (byte_words[k]) sym_expect_q.push_back(byte_words[k]);
  endfunction

  task automatic send_word(input logic cmd, input logic [IdxW-1:0] nidx,
                           input logic [IdxW-1:0] lidx, input logic [IdxW-1:0] ridx,
                           input logic lp, input logic rp,
                           input logic [SymW-1:0] sym, input logic [SymW-1:0] code);
    node_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    node_index_i    <= nidx;
    left_index_i    <= lidx;
    right_index_i   <= ridx;
    left_present_i  <= lp;
    right_present_i <= rp;
    node_symbol_i   <= sym;
    code_byte_i     <= code;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (cmd == htbd_pkg::CmdLoad) begin
      loads_sent++;
      entry = '{right_present: rp, left_present: lp, right_index: ridx,
                left_index: lidx, symbol: sym};
      apply_node_load(nidx, entry);
    end else begin
      bytes_sent++;
      predict_code_byte(code);
    end
  endtask

  task automatic load_node(input logic [IdxW-1:0] nidx, input logic [IdxW-1:0] lidx,
                           input logic [IdxW-1:0] ridx, input logic lp, input logic rp,
                           input logic [SymW-1:0] sym);
    send_word(htbd_pkg::CmdLoad, nidx, lidx, ridx, lp, rp, sym, SymW'($urandom_range(255)));
  endtask

  task automatic decode_byte(input logic [SymW-1:0] code);
    send_word(htbd_pkg::CmdDecode, IdxW'($urandom_range(511)), IdxW'($urandom_range(511)),
              IdxW'($urandom_range(511)), 1'($urandom_range(1)), 1'($urandom_range(1)),
              SymW'($urandom_range(255)), code);
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (sym_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_root(input logic [IdxW-1:0] idx);
    drain_words();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= idx;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    root_idx = idx;
    walk_idx = idx;
  endtask

  // present children point at nodes already in the table or at the node itself
  task automatic load_random_node();
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] lidx;
    logic [IdxW-1:0] ridx;
    logic            lp;
    logic            rp;
    idx  = IdxW'($urandom_range(MaxNodes - 1));
    lp   = 1'($urandom_range(1));
    rp   = 1'($urandom_range(1));
    lidx = IdxW'($urandom_range(511));
    ridx = IdxW'($urandom_range(511));
    if (lp) lidx = ($urandom_range(7) == 0) ? idx : pick_loaded_node();
    if (rp) ridx = ($urandom_range(7) == 0) ? idx : pick_loaded_node();
    load_node(idx, lidx, ridx, lp, rp, SymW'($urandom_range(255)));
  endtask

  // leaves first, then internal nodes in merge order
  task automatic build_tree(input int n_leaves, output logic [IdxW-1:0] top);
    int   pool[$];
    int   base;
    int   next_idx;
    int   pa;
    int   a;
    int   b;
    logic lp;
    logic rp;
    base = $urandom_range(MaxNodes - (2 * n_leaves - 1));
    for (int i = 0; i < n_leaves; i++) begin
      load_node(IdxW'(base + i), IdxW'($urandom_range(511)), IdxW'($urandom_range(511)),
                1'b0, 1'b0, SymW'($urandom_range(255)));
      pool.push_back(base + i);
    end
    next_idx = base + n_leaves;
    while (pool.size() > 1) begin
      pa = $urandom_range(pool.size() - 1);
      a  = pool[pa];
      pool.delete(pa);
      pa = $urandom_range(pool.size() - 1);
      b  = pool[pa];
      pool.delete(pa);
      lp = 1'b1;
      rp = 1'b1;
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) lp = 1'b0;
        else rp = 1'b0;
      end
      load_node(IdxW'(next_idx), IdxW'(a), IdxW'(b), lp, rp, SymW'($urandom_range(255)));
      pool.push_back(next_idx);
      next_idx++;
    end
    top = IdxW'(pool[0]);
  endtask

  task automatic test_leaf_root();
    set_root('0);
    load_node('0, '1, '1, 1'b0, 1'b0, 8'hA5);
    decode_byte(8'h00);
  endtask

  task automatic test_short_codes();
    load_node(9'd1, 9'd0, 9'd511, 1'b0, 1'b0, 8'h00);
    load_node(9'd2, 9'd511, 9'd0, 1'b0, 1'b0, 8'hFF);
    load_node(9'd511, 9'h155, 9'h0AA, 1'b0, 1'b0, 8'h5A);
    load_node(9'd510, 9'd2, 9'd511, 1'b1, 1'b1, 8'h11);
    load_node(9'd3, 9'd1, 9'd510, 1'b1, 1'b1, 8'h22);
    set_root(9'd3);
    decode_byte(8'hFF);
    decode_byte(8'h00);
    decode_byte(8'hA5);
    decode_byte(8'h80);
  endtask

  task automatic test_absent_child();
    load_node(9'd5, 9'd1, 9'h1FF, 1'b1, 1'b0, 8'h33);
    load_node(9'd6, 9'd5, 9'd2, 1'b1, 1'b1, 8'h44);
    load_node(9'd8, 9'h100, 9'd2, 1'b0, 1'b1, 8'h55);
    set_root(9'd6);
    decode_byte(8'h01);
    decode_byte(8'h7F);
    set_root(9'd8);
    decode_byte(8'h80);
  endtask

  task automatic test_silent_bytes();
    load_node(9'd7, 9'd7, 9'd7, 1'b1, 1'b1, 8'h66);
    set_root(9'd7);
    decode_byte(8'h3C);
    decode_byte(8'hC3);
    load_node('1, '1, '1, 1'b1, 1'b1, '1);
    set_root('1);
    decode_byte(8'hFF);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int              start;
    logic [IdxW-1:0] top;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = words_sent;
    while (words_sent - start < PhaseWords) begin
      build_tree(($urandom_range(5) == 0) ? $urandom_range(9, 20) : $urandom_range(2, 6), top);
      set_root(top);
      repeat ($urandom_range(6, 20)) begin
        case ($urandom_range(19))
          0: load_random_node();
          1: set_root(pick_loaded_node());
          2: drain_words();
          default: decode_byte(SymW'($urandom_range(255)));
        endcase
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    sym_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sym_expect_q.size() == 0) begin
        if (err_count < 10)
          $display("error: unexpected word sym=%02h bad_path=%0b last=%0b",
                   symbol_o, bad_path_o, last_o);
        err_count++;
      end else begin
        want = sym_expect_q.pop_front();
        words_checked++;
        if (bad_path_o) bad_paths_seen++;
        if (symbol_o !== want.symbol || bad_path_o !== want.bad_path ||
            last_o !== want.last) begin
          if (err_count < 10)
            $display({"error: word %0d expected sym=%02h bad_path=%0b last=%0b,",
                      " got sym=%02h bad_path=%0b last=%0b"},
                     words_checked, want.symbol, want.bad_path, want.last,
                     symbol_o, bad_path_o, last_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL huffman_tree_bit_decoder_core");
      $finish;
    end
  end

  initial begin
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    words_sent      = 0;
    loads_sent      = 0;
    bytes_sent      = 0;
    root_idx        = '0;
    walk_idx        = '0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    cmd_i           <= htbd_pkg::CmdLoad;
    node_index_i    <= '0;
    left_index_i    <= '0;
    right_index_i   <= '0;
    left_present_i  <= 1'b0;
    right_present_i <= 1'b0;
    node_symbol_i   <= '0;
    code_byte_i     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_leaf_root();
    test_short_codes();
    test_absent_child();
    test_silent_bytes();
    test_random_traffic(0, 0);
    test_random_traffic(55, 0);
    test_random_traffic(0, 55);
    test_random_traffic(23, 23);
    drain_words();

    $display("sent %0d words: %0d node loads and %0d code bytes, across four idle/stall mixes",
             words_sent, loads_sent, bytes_sent);
    $display("checked %0d decoded words, %0d bad-path restarts, %0d mismatches",
             words_checked, bad_paths_seen, err_count);
    if (err_count == 0) begin
      $display("PASS huffman_tree_bit_decoder_core");
    end else begin
      $display("FAIL huffman_tree_bit_decoder_core");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/htbd_pkg.sv
sv/htbd_ram.sv
sv/huffman_tree_bit_decoder_core.sv
verif/tb.sv
